>>> hw/rtl/rpsd_pkg.sv
`default_nettype none

package rpsd_pkg;

    localparam int RPSD_CLIENTS = 4;
    localparam int RPSD_SUBPADS = 4;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PERCENT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NONZERO  = 1'd1;

    localparam logic [9:0] GAIN_RESET = 10'd100;
    localparam logic [7:0] MIN_RESET  = 8'd1;

    localparam logic [7:0] MIN_PACKET_LEN = 8'd10;

    // neutral carrier bytes of one half
    localparam logic [7:0] CARRIER_B0 = 8'h00;
    localparam logic [7:0] CARRIER_B1 = 8'h01;
    localparam logic [7:0] CARRIER_B2 = 8'h40;
    localparam logic [7:0] CARRIER_B3 = 8'h40;
    localparam logic [6:0] LOW_BIAS   = 7'h40;
    localparam logic [6:0] HIGH_BIAS  = 7'h01;

    // raw strength values before scaling
    localparam int V_W    = 10;
    localparam int V_CNT  = 6;
    localparam int V_IDX_W = 3;
    localparam logic [V_IDX_W-1:0] V_HIGH_A   = 3'd0;
    localparam logic [V_IDX_W-1:0] V_LOW_A    = 3'd1;
    localparam logic [V_IDX_W-1:0] V_HIGH_B   = 3'd2;
    localparam logic [V_IDX_W-1:0] V_LOW_B    = 3'd3;
    localparam logic [V_IDX_W-1:0] V_COARSE_A = 3'd4;
    localparam logic [V_IDX_W-1:0] V_COARSE_B = 3'd5;

    // s = p / 100 for p < 25600 via reciprocal; p >= 25600 saturates
    localparam int P_W = V_W + CFG_W;
    localparam logic [P_W-1:0] P_SAT = 20'd25600;
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam logic [7:0] STRENGTH_MAX = 8'd255;

    typedef struct packed {
        logic [2:0]                  client;
        logic [1:0]                  subpad;
        logic [63:0]                 pattern;
        logic                        allow;
        logic                        quiet_a;
        logic                        quiet_b;
        logic [V_CNT-1:0][V_W-1:0]   v;
    } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/rpsd_queue.sv
`default_nettype none

module rpsd_queue
    import rpsd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_data,
    input  wire logic  pop,
    output item_t      head,
    output logic       empty,
    output logic       full
);

    item_t      mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rpsd_front.sv
`default_nettype none

module rpsd_front
    import rpsd_pkg::*;
#(
    parameter int CLIENTS = RPSD_CLIENTS,
    parameter int SUBPADS = RPSD_SUBPADS
)
(
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  client_index,
    input  wire logic [2:0]  subpad_index,
    input  wire logic [7:0]  packet_length,
    input  wire logic [63:0] pattern_bytes,
    input  wire logic        allow_neutral,
    input  wire logic        q_full,
    output logic             q_push,
    output item_t            q_data
);

    function automatic logic [7:0] absd8(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic is_quiet(input logic [31:0] h);
        logic zero;
        logic carrier;
        zero    = (h == 32'd0);
        carrier = (h[7:0] == CARRIER_B0) && (h[15:8] == CARRIER_B1) &&
                  (h[23:16] == CARRIER_B2) && (h[31:24] == CARRIER_B3);
        return zero || carrier;
    endfunction

    function automatic logic [V_W-1:0] v_high(input logic [31:0] h);
        logic [6:0]  d1;
        logic [15:0] third;
        d1    = (h[14:8] > HIGH_BIAS) ? (h[14:8] - HIGH_BIAS) : (HIGH_BIAS - h[14:8]);
        third = 16'(h[7:0]) * 16'd171;
        return V_W'({3'd0, d1} * 10'd3) + V_W'(third[15:9]);
    endfunction

    function automatic logic [V_W-1:0] v_low(input logic [31:0] h);
        logic [6:0] d2;
        logic [6:0] d3;
        d2 = (h[22:16] > LOW_BIAS) ? (h[22:16] - LOW_BIAS) : (LOW_BIAS - h[22:16]);
        d3 = (h[30:24] > LOW_BIAS) ? (h[30:24] - LOW_BIAS) : (LOW_BIAS - h[30:24]);
        return V_W'({3'd0, d3} * 10'd3) + V_W'(d2[6:1]);
    endfunction

    function automatic logic [V_W-1:0] v_coarse(input logic [31:0] h);
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [7:0]  d2;
        logic [7:0]  d3;
        logic [7:0]  m01;
        logic [7:0]  m23;
        logic [7:0]  mx;
        logic [9:0]  sum;
        d0  = absd8(h[7:0], CARRIER_B0);
        d1  = absd8(h[15:8], CARRIER_B1);
        d2  = absd8(h[23:16], CARRIER_B2);
        d3  = absd8(h[31:24], CARRIER_B3);
        m01 = (d0 > d1) ? d0 : d1;
        m23 = (d2 > d3) ? d2 : d3;
        mx  = (m01 > m23) ? m01 : m23;
        sum = 10'(d0) + 10'(d1) + 10'(d2) + 10'(d3);
        return V_W'({mx, 1'b0}) + V_W'(sum[9:2]);
    endfunction

    logic [31:0] half_a;
    logic [31:0] half_b;
    logic        keep;

    assign half_a = pattern_bytes[31:0];
    assign half_b = pattern_bytes[63:32];

    assign keep = (32'(client_index) < CLIENTS) && (32'(subpad_index) < SUBPADS) &&
                  (packet_length >= MIN_PACKET_LEN);

    // dropped packets are still consumed, they just never reach the queue
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full && keep;

    always_comb
    begin
        q_data         = '0;
        q_data.client  = client_index;
        q_data.subpad  = subpad_index[1:0];
        q_data.pattern = pattern_bytes;
        q_data.allow   = allow_neutral;
        q_data.quiet_a = is_quiet(half_a);
        q_data.quiet_b = is_quiet(half_b);
        if (!q_data.quiet_a)
        begin
            q_data.v[V_HIGH_A]   = v_high(half_a);
            q_data.v[V_LOW_A]    = v_low(half_a);
            q_data.v[V_COARSE_A] = v_coarse(half_a);
        end
        if (!q_data.quiet_b)
        begin
            q_data.v[V_HIGH_B]   = v_high(half_b);
            q_data.v[V_LOW_B]    = v_low(half_b);
            q_data.v[V_COARSE_B] = v_coarse(half_b);
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/rpsd_back.sv
`default_nettype none

module rpsd_back
    import rpsd_pkg::*;
#(
    parameter int CLIENTS = RPSD_CLIENTS,
    parameter int SUBPADS = RPSD_SUBPADS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 q_empty,
    input  wire item_t                q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                event_client,
    output logic [1:0]                event_subpad,
    output logic [7:0]                low_strength,
    output logic [7:0]                high_strength,
    output logic                      duration_ticks,
    output logic [63:0]               raw_pattern,
    output logic [15:0]               sequence_count
);

    localparam int SLOTS  = CLIENTS * SUBPADS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_DECIDE} state_t;

    state_t             state_reg, state_next;
    item_t              item_reg, item_next;
    logic [V_IDX_W-1:0] iss_cnt_reg, iss_cnt_next;
    logic [P_W-1:0]     p_reg, p_next;
    logic [V_IDX_W-1:0] p_idx_reg, p_idx_next;
    logic               p_vld_reg, p_vld_next;
    logic [7:0]         res_reg [V_CNT];
    logic [CFG_W-1:0]   gain_reg;
    logic [7:0]         min_reg;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         client_reg, client_next;
    logic [1:0]         subpad_reg, subpad_next;
    logic [7:0]         low_reg, low_next;
    logic [7:0]         high_reg, high_next;
    logic               dur_reg, dur_next;
    logic [63:0]        raw_reg, raw_next;
    logic [15:0]        seq_reg, seq_next;

    logic               slot_active_reg [SLOTS];
    logic [15:0]        slot_seq_reg [SLOTS];

    logic [27:0]        recip_prod;
    logic [7:0]         quot;
    logic [7:0]         scaled;
    logic [7:0]         low_p;
    logic [7:0]         high_p;
    logic [7:0]         low_f;
    logic [7:0]         high_f;
    logic               neutral;
    logic               emit;
    logic               load;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        seq_inc;

    // second scaler stage: divide by 100, floor, saturate, nonzero >= min
    assign recip_prod = 28'(p_reg[14:0]) * 28'(RECIP_100);
    assign quot       = recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];

    always_comb
    begin
        if (p_reg >= P_SAT)
        begin
            scaled = STRENGTH_MAX;
        end
        else if (quot == 8'd0)
        begin
            scaled = 8'd0;
        end
        else if (quot < min_reg)
        begin
            scaled = min_reg;
        end
        else
        begin
            scaled = quot;
        end
    end

    assign low_p  = (res_reg[V_LOW_A] > res_reg[V_LOW_B]) ? res_reg[V_LOW_A] : res_reg[V_LOW_B];
    assign high_p = (res_reg[V_HIGH_A] > res_reg[V_HIGH_B]) ?
                    res_reg[V_HIGH_A] : res_reg[V_HIGH_B];

    always_comb
    begin
        low_f  = low_p;
        high_f = high_p;
        // both precise strengths vanished on two live halves: coarse decode
        if (low_p == 8'd0 && high_p == 8'd0 && !item_reg.quiet_a && !item_reg.quiet_b)
        begin
            low_f  = res_reg[V_COARSE_A];
            high_f = res_reg[V_COARSE_B];
        end
    end

    assign neutral = (low_f == 8'd0) && (high_f == 8'd0);
    assign slot    = SLOT_W'(32'(item_reg.client) * SUBPADS + 32'(item_reg.subpad));
    assign emit    = !neutral || (item_reg.allow && slot_active_reg[slot]);
    assign seq_inc = slot_seq_reg[slot] + 16'd1;
    assign load    = (state_reg == ST_DECIDE) && emit && (!out_valid_reg || out_ready);
    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        iss_cnt_next   = iss_cnt_reg;
        p_next         = p_reg;
        p_idx_next     = p_idx_reg;
        p_vld_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        client_next    = client_reg;
        subpad_next    = subpad_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        dur_next       = dur_reg;
        raw_next       = raw_reg;
        seq_next       = seq_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    item_next    = q_head;
                    iss_cnt_next = '0;
                    state_next   = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                p_next       = P_W'(item_reg.v[iss_cnt_reg]) * P_W'(gain_reg);
                p_idx_next   = iss_cnt_reg;
                p_vld_next   = 1'b1;
                iss_cnt_next = iss_cnt_reg + V_IDX_W'(1);
                if (iss_cnt_reg == V_IDX_W'(V_CNT - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!emit)
                begin
                    state_next = ST_IDLE;
                end
                else if (load)
                begin
                    out_valid_next = 1'b1;
                    client_next    = item_reg.client;
                    subpad_next    = item_reg.subpad;
                    low_next       = neutral ? 8'd0 : low_f;
                    high_next      = neutral ? 8'd0 : high_f;
                    dur_next       = !neutral;
                    raw_next       = item_reg.pattern;
                    seq_next       = seq_inc;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            iss_cnt_reg   <= '0;
            client_reg    <= '0;
            subpad_reg    <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            dur_reg       <= 1'b0;
            raw_reg       <= '0;
            seq_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
            iss_cnt_reg   <= iss_cnt_next;
            client_reg    <= client_next;
            subpad_reg    <= subpad_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            dur_reg       <= dur_next;
            raw_reg       <= raw_next;
            seq_reg       <= seq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        p_reg      <= p_next;
        p_idx_reg  <= p_idx_next;
        if (p_vld_reg)
        begin
            res_reg[p_idx_reg] <= scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            min_reg  <= MIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN_PERCENT: gain_reg <= cfg_data;
                CFG_MIN_NONZERO:  min_reg  <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_active_reg[i] <= 1'b0;
                slot_seq_reg[i]    <= 16'd0;
            end
        end
        else if (load)
        begin
            slot_active_reg[slot] <= !neutral;
            slot_seq_reg[slot]    <= seq_inc;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_client   = client_reg;
    assign event_subpad   = subpad_reg;
    assign low_strength   = low_reg;
    assign high_strength  = high_reg;
    assign duration_ticks = dur_reg;
    assign raw_pattern    = raw_reg;
    assign sequence_count = seq_reg;

endmodule

`default_nettype wire

>>> hw/rtl/rumble_pattern_strength_decoder_core.sv
`default_nettype none

// channel   | signals                         | carries
// ----------+---------------------------------+----------------------------------
// s_axis    | tvalid tready tdata[79:0] tuser | one rumble packet per transaction
// m_axis    | tvalid tready tdata[103:0] tuser| one rumble event per transaction
// cfg       | cfg_we cfg_index cfg_data       | register write, index 0 gain, 1 min
//
// In the back end a packet is popped and its six values pass through the shared
// gain scaler (multiply, then divide-by-100 stage); a drain and a decide state
// follow. A two-entry queue lets the input keep taking packets while the back end
// works or the output register is stalled. Dropped packets never enter the queue.
// Reset clears slot state and returns gain to 100 and min strength to 1.

module rumble_pattern_strength_decoder_core
    import rpsd_pkg::*;
#(
    parameter int CLIENTS = RPSD_CLIENTS,
    parameter int SUBPADS = RPSD_SUBPADS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // client_index[2:0], subpad_index[5:3], packet_length[13:6],
    // pattern_bytes[77:14], zero pad[79:78]
    input  wire logic [79:0]          s_axis_tdata,
    // allow_neutral[0]
    input  wire logic                 s_axis_tuser,

    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // event_client[2:0], event_subpad[4:3], low_strength[12:5],
    // high_strength[20:13], raw_pattern[84:21], sequence_count[100:85],
    // zero pad[103:101]
    output logic [103:0]              m_axis_tdata,
    // duration_ticks[0]
    output logic                      m_axis_tuser
);

    item_t       q_data;
    item_t       q_head;
    logic        q_push;
    logic        q_pop;
    logic        q_empty;
    logic        q_full;
    logic [2:0]  event_client;
    logic [1:0]  event_subpad;
    logic [7:0]  low_strength;
    logic [7:0]  high_strength;
    logic [63:0] raw_pattern;
    logic [15:0] sequence_count;

    rpsd_front #(
        .CLIENTS (CLIENTS),
        .SUBPADS (SUBPADS)
    ) u_front (
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .client_index  (s_axis_tdata[2:0]),
        .subpad_index  (s_axis_tdata[5:3]),
        .packet_length (s_axis_tdata[13:6]),
        .pattern_bytes (s_axis_tdata[77:14]),
        .allow_neutral (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    rpsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    rpsd_back #(
        .CLIENTS (CLIENTS),
        .SUBPADS (SUBPADS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .event_client   (event_client),
        .event_subpad   (event_subpad),
        .low_strength   (low_strength),
        .high_strength  (high_strength),
        .duration_ticks (m_axis_tuser),
        .raw_pattern    (raw_pattern),
        .sequence_count (sequence_count)
    );

    assign m_axis_tdata = {3'd0, sequence_count, raw_pattern, high_strength,
                           low_strength, event_subpad, event_client};

endmodule

`default_nettype wire
